/* rtl/srbf_pkg.sv */
// srbf_pkg: types and constants for the source rate ban filter.
// No dependencies; used by every module in rtl.
`timescale 1ns / 1ps
package srbf_pkg;
    localparam int FLOW_ENTRIES = 32;
    localparam int BAN_ENTRIES  = 8;
    localparam int FLOW_IDX_W   = $clog2(FLOW_ENTRIES);
    localparam int BAN_IDX_W    = $clog2(BAN_ENTRIES);
    localparam logic [15:0] MIN_FRAME_LEN = 16'd34;
    localparam logic [31:0] WINDOW_RESET  = 32'd2000000000;
    localparam logic [7:0]  PROTO_RESET   = 8'd6;
    localparam logic        CFG_WINDOW    = 1'b0;
    localparam logic        CFG_PROTO     = 1'b1;

    typedef struct packed {
        logic [15:0] frame_len;
        logic [7:0]  ip_protocol;
        logic [31:0] source_addr;
        logic [62:0] now_ns;
    } srbf_in_t;

    typedef struct packed {
        logic        verdict;
        logic        newly_banned;
        logic [31:0] packets_seen;
    } srbf_out_t;

    // one flow table row as stored in memory
    typedef struct packed {
        logic [31:0] addr;
        logic [62:0] last_time;
        logic [31:0] count;
    } srbf_flow_t;
endpackage

/* rtl/srbf_ban_list.sv */
// srbf_ban_list: ban list of source addresses with lookup and insert.
// Depends on srbf_pkg.
`timescale 1ns / 1ps
module srbf_ban_list
    import srbf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] lookup_addr,
    output logic        banned,
    input  logic        add_req,
    input  logic [31:0] add_addr,
    output logic        add_ok
);
    logic [BAN_ENTRIES-1:0] valid_reg;
    logic [31:0]            addr_reg [BAN_ENTRIES];
    logic [BAN_ENTRIES-1:0] free_onehot;

    always_comb begin
        banned = 1'b0;
        for (int i = 0; i < BAN_ENTRIES; i++) begin
            if (valid_reg[i] && addr_reg[i] == lookup_addr) begin
                banned = 1'b1;
            end
        end
    end

    // lowest free slot
    assign free_onehot = ~valid_reg & (valid_reg + 1'b1);
    assign add_ok = |free_onehot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (add_req) begin
            valid_reg <= valid_reg | free_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < BAN_ENTRIES; i++) begin
            if (add_req && free_onehot[i]) begin
                addr_reg[i] <= add_addr;
            end
        end
    end

`ifndef ASSERT_OFF
    a_free_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(free_onehot)) else $error("ban free slot not onehot");
    a_valid_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        add_req && add_ok |=> $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("ban insert lost");
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !add_req |=> $stable(valid_reg)) else $error("ban valid changed");
`endif
endmodule

/* rtl/source_rate_ban_filter.sv */
// source_rate_ban_filter: top level; flow table in one synchronous memory,
// LRU ages and valid bits in flops, ban list in srbf_ban_list.
// Short, other-protocol and banned requests go IDLE, CHECK, OUT; tracked
// packets go IDLE, CHECK, SCAN (one memory read per entry scanned), UPD, OUT.
// A new request is taken only in IDLE with no result pending, so requests
// never overlap; a tracked request is held for as long as its scan runs.
// Reset: synchronous, active low; clears valid bits, ages to index order,
// ban list, and config registers to their defaults.
`timescale 1ns / 1ps
module source_rate_ban_filter
    import srbf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  srbf_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output srbf_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]            state_reg, state_next;
    srbf_in_t              req_reg;
    logic [31:0]           window_reg;
    logic [7:0]            proto_reg;
    logic [FLOW_IDX_W:0]   scan_reg;
    logic                  hit_reg;
    logic [FLOW_IDX_W-1:0] hit_idx_reg;
    srbf_flow_t            rd_reg;
    logic [FLOW_ENTRIES-1:0] fvalid_reg;
    logic [FLOW_IDX_W-1:0] age_reg [FLOW_ENTRIES];
    srbf_flow_t            flow_mem [FLOW_ENTRIES];
    srbf_out_t             out_reg;
    logic                  out_valid_reg;

    logic                  banned;
    logic                  pass_thru;
    logic                  ban_add_req;
    logic                  ban_add_ok;
    logic [FLOW_IDX_W-1:0] lru_idx;
    logic [FLOW_IDX_W-1:0] rd_idx;
    logic [FLOW_IDX_W-1:0] sel_idx;
    logic                  rd_match;
    logic [62:0]           gap;
    logic                  fast;
    srbf_flow_t            wr_row;

    srbf_ban_list u_ban (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lookup_addr (req_reg.source_addr),
        .banned      (banned),
        .add_req     (ban_add_req),
        .add_addr    (req_reg.source_addr),
        .add_ok      (ban_add_ok)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        lru_idx = '0;
        for (int i = 0; i < FLOW_ENTRIES; i++) begin
            if (age_reg[i] == FLOW_IDX_W'(FLOW_ENTRIES - 1)) begin
                lru_idx = FLOW_IDX_W'(i);
            end
        end
    end

    // short frames and other protocols pass without any lookup
    assign pass_thru = req_reg.frame_len < MIN_FRAME_LEN
                       || req_reg.ip_protocol != proto_reg;

    // rd_idx names the entry held in rd_reg, which was read in the cycle before
    assign rd_idx   = scan_reg[FLOW_IDX_W-1:0] - 1'b1;
    assign rd_match = fvalid_reg[rd_idx] && rd_reg.addr == req_reg.source_addr;
    assign sel_idx  = hit_reg ? hit_idx_reg : lru_idx;
    assign gap      = req_reg.now_ns - rd_reg.last_time;
    assign fast     = gap < {31'd0, window_reg};
    assign ban_add_req = (state_reg == ST_UPD) && hit_reg && fast;

    always_comb begin
        wr_row.addr      = req_reg.source_addr;
        wr_row.last_time = req_reg.now_ns;
        wr_row.count     = 32'd1;
        if (hit_reg) begin
            wr_row.count = (rd_reg.count == 32'hFFFF_FFFF) ? rd_reg.count
                                                           : rd_reg.count + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid && s_ready) state_next = ST_CHECK;
            ST_CHECK: begin
                if (pass_thru || banned) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_reg == (FLOW_IDX_W+1)'(FLOW_ENTRIES)
                    || (scan_reg != 0 && rd_match)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            proto_reg     <= PROTO_RESET;
            out_valid_reg <= 1'b0;
            fvalid_reg    <= '0;
            scan_reg      <= '0;
            hit_reg       <= 1'b0;
            for (int i = 0; i < FLOW_ENTRIES; i++) begin
                age_reg[i] <= FLOW_IDX_W'(i);
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_WINDOW: window_reg <= cfg_data;
                    CFG_PROTO:  proto_reg  <= cfg_data[7:0];
                    default:    ;
                endcase
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_CHECK) begin
                scan_reg <= '0;
                hit_reg  <= 1'b0;
                out_valid_reg <= 1'b0;
                if (state_next == ST_OUT) begin
                    out_valid_reg <= 1'b1;
                end
            end
            if (state_reg == ST_SCAN) begin
                if (scan_reg != 0 && rd_match) begin
                    hit_reg <= 1'b1;
                end else begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (state_reg == ST_UPD) begin
                fvalid_reg[sel_idx] <= 1'b1;
                for (int i = 0; i < FLOW_ENTRIES; i++) begin
                    if (age_reg[i] < age_reg[sel_idx]) begin
                        age_reg[i] <= age_reg[i] + 1'b1;
                    end
                end
                age_reg[sel_idx] <= '0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_SCAN) begin
            // hold the matching row for the update
            if (scan_reg != 0 && rd_match) begin
                hit_idx_reg <= rd_idx;
            end else begin
                rd_reg <= flow_mem[scan_reg[FLOW_IDX_W-1:0]];
            end
        end
        if (state_reg == ST_UPD) begin
            flow_mem[sel_idx] <= wr_row;
        end
        if (state_reg == ST_CHECK) begin
            out_reg.verdict      <= banned && !pass_thru;
            out_reg.newly_banned <= 1'b0;
            out_reg.packets_seen <= '0;
        end
        if (state_reg == ST_UPD) begin
            out_reg.verdict      <= 1'b0;
            out_reg.newly_banned <= ban_add_req && ban_add_ok;
            out_reg.packets_seen <= wr_row.count;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready) else $error("request taken while busy");
    a_out_after_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPD |=> m_valid) else $error("result missing after update");
    a_mru_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPD |=> age_reg[$past(sel_idx)] == '0)
        else $error("updated entry not most recent");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped");
`endif
endmodule
